// ===== rtl/core/ccpp_pkg.sv =====
// package for the cubic curve point projection core
// holds defaults, command and status types and small helpers
// no dependencies
`timescale 1ns / 1ps

package ccpp_pkg;

    // default parameter values
    localparam int FRAC_BITS_DEF  = 16;
    localparam int MAX_PASSES_DEF = 100;

    // configuration register indexes
    localparam logic [2:0] CFG_COEF_CONST  = 3'd0;
    localparam logic [2:0] CFG_COEF_LINEAR = 3'd1;
    localparam logic [2:0] CFG_COEF_SQUARE = 3'd2;
    localparam logic [2:0] CFG_COEF_CUBE   = 3'd3;
    localparam logic [2:0] CFG_TOLERANCE   = 3'd4;
    localparam logic [2:0] CFG_SEARCH_LOW  = 3'd5;
    localparam logic [2:0] CFG_SEARCH_HIGH = 3'd6;

    // dot product pairs
    localparam logic [1:0] P_A = 2'd0;  // start vector . mid-to-start chord
    localparam logic [1:0] P_B = 2'd1;  // mid vector . mid-to-start chord
    localparam logic [1:0] P_C = 2'd2;  // end vector . end-to-mid chord
    localparam logic [1:0] P_D = 2'd3;  // mid vector . end-to-mid chord

    // sign product pairs
    localparam logic [1:0] SP_AB = 2'd0;
    localparam logic [1:0] SP_DC = 2'd1;
    localparam logic [1:0] SP_AC = 2'd2;

    // last horner stage uses the 24 bit coefficient shift
    localparam logic [1:0] HORNER_LAST = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_TOL, ST_CV_HI, ST_CV_LO, ST_CV_FIN, ST_YS, ST_VI, ST_IDOT,
        ST_BRK, ST_RESY, ST_MID, ST_VP, ST_PDOT, ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        M_NONE, M_TOL, M_HI, M_LO, M_DOT, M_SGN, M_SQ
    } t_mul_op;

    typedef enum logic [4:0] {
        A_NOP, A_LOAD, A_TOL_XS, A_SAVE_PH, A_HORNER, A_YS_XE, A_VEC_INIT, A_ACC,
        A_DOT, A_SGN, A_SQ0, A_PX, A_RES_Y, A_MID, A_VEC_PASS, A_DECIDE, A_PUSH
    } t_act;

    typedef struct packed {
        t_mul_op    mul_op;
        logic [1:0] mpair;
        logic       comp;
        t_act       act;
        logic [1:0] apair;
        logic [1:0] stage;
    } t_cmd;

    typedef struct packed {
        logic bracket;
        logic stop;
        logic out_free;
    } t_status;

    // saturating 32 bit difference
    function automatic logic signed [31:0] diff32(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        if (d > 33'sd2147483647)
            diff32 = 32'sh7fff_ffff;
        else if (d < -33'sd2147483648)
            diff32 = 32'sh8000_0000;
        else
            diff32 = d[31:0];
    endfunction

    // magnitude of a signed 32 bit value
    function automatic logic [31:0] abs32(input logic signed [31:0] a);
        abs32 = a[31] ? (~a + 32'd1) : a;
    endfunction

endpackage

// ===== rtl/core/ccpp_ctrl.sv =====
// sequencer for the cubic curve point projection core
// issues one command per cycle to the datapath; uses ccpp_pkg
`timescale 1ns / 1ps

module ccpp_ctrl import ccpp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state     r_state, n_state;
    t_state     r_ret, n_ret;
    logic [1:0] r_stage, n_stage;
    logic [3:0] r_step, n_step;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_stage <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_stage <= n_stage;
            r_step  <= n_step;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_stage = r_stage;
        n_step  = r_step;
        o_cmd   = '{mul_op: M_NONE, mpair: P_A, comp: 1'b0, act: A_NOP,
                    apair: P_A, stage: r_stage};
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.act    = A_LOAD;
                    o_cmd.mul_op = M_TOL;
                    n_state      = ST_TOL;
                end
            end
            ST_TOL: begin
                o_cmd.act = A_TOL_XS;
                n_stage   = '0;
                n_ret     = ST_YS;
                n_state   = ST_CV_HI;
            end
            ST_CV_HI: begin
                o_cmd.mul_op = M_HI;
                n_state      = ST_CV_LO;
            end
            ST_CV_LO: begin
                o_cmd.mul_op = M_LO;
                o_cmd.act    = A_SAVE_PH;
                n_state      = ST_CV_FIN;
            end
            ST_CV_FIN: begin
                o_cmd.act = A_HORNER;
                if (r_stage == HORNER_LAST) begin
                    n_stage = '0;
                    n_state = r_ret;
                end else begin
                    n_stage = r_stage + 2'd1;
                    n_state = ST_CV_HI;
                end
            end
            ST_YS: begin
                o_cmd.act = A_YS_XE;
                n_ret     = ST_VI;
                n_state   = ST_CV_HI;
            end
            ST_VI: begin
                o_cmd.act = A_VEC_INIT;
                n_step    = '0;
                n_state   = ST_IDOT;
            end
            ST_IDOT: begin
                n_step = r_step + 4'd1;
                unique case (r_step)
                    4'd0: begin
                        o_cmd.mul_op = M_DOT; o_cmd.mpair = P_A;
                    end
                    4'd1: begin
                        o_cmd.mul_op = M_DOT; o_cmd.mpair = P_A; o_cmd.comp = 1'b1;
                        o_cmd.act = A_ACC;
                    end
                    4'd2: begin
                        o_cmd.mul_op = M_DOT; o_cmd.mpair = P_C;
                        o_cmd.act = A_DOT; o_cmd.apair = P_A;
                    end
                    4'd3: begin
                        o_cmd.mul_op = M_DOT; o_cmd.mpair = P_C; o_cmd.comp = 1'b1;
                        o_cmd.act = A_ACC;
                    end
                    4'd4: begin
                        o_cmd.act = A_DOT; o_cmd.apair = P_C;
                    end
                    4'd5: begin
                        o_cmd.mul_op = M_SGN; o_cmd.mpair = SP_AC;
                    end
                    4'd6: begin
                        o_cmd.act = A_SGN; o_cmd.apair = SP_AC;
                        n_state = ST_BRK;
                    end
                    default: n_state = ST_BRK;
                endcase
            end
            ST_BRK: begin
                if (i_status.bracket) begin
                    n_state = ST_MID;
                end else begin
                    o_cmd.act = A_PX;
                    n_ret     = ST_RESY;
                    n_state   = ST_CV_HI;
                end
            end
            ST_RESY: begin
                o_cmd.act = A_RES_Y;
                n_state   = ST_OUT;
            end
            ST_MID: begin
                o_cmd.act = A_MID;
                n_ret     = ST_VP;
                n_state   = ST_CV_HI;
            end
            ST_VP: begin
                o_cmd.act = A_VEC_PASS;
                n_step    = '0;
                n_state   = ST_PDOT;
            end
            ST_PDOT: begin
                n_step = r_step + 4'd1;
                unique case (r_step)
                    4'd0: begin
                        o_cmd.mul_op = M_DOT; o_cmd.mpair = P_A;
                    end
                    4'd1: begin
                        o_cmd.mul_op = M_DOT; o_cmd.mpair = P_A; o_cmd.comp = 1'b1;
                        o_cmd.act = A_ACC;
                    end
                    4'd2: begin
                        o_cmd.mul_op = M_DOT; o_cmd.mpair = P_B;
                        o_cmd.act = A_DOT; o_cmd.apair = P_A;
                    end
                    4'd3: begin
                        o_cmd.mul_op = M_DOT; o_cmd.mpair = P_B; o_cmd.comp = 1'b1;
                        o_cmd.act = A_ACC;
                    end
                    4'd4: begin
                        o_cmd.mul_op = M_DOT; o_cmd.mpair = P_C;
                        o_cmd.act = A_DOT; o_cmd.apair = P_B;
                    end
                    4'd5: begin
                        o_cmd.mul_op = M_DOT; o_cmd.mpair = P_C; o_cmd.comp = 1'b1;
                        o_cmd.act = A_ACC;
                    end
                    4'd6: begin
                        o_cmd.mul_op = M_DOT; o_cmd.mpair = P_D;
                        o_cmd.act = A_DOT; o_cmd.apair = P_C;
                    end
                    4'd7: begin
                        o_cmd.mul_op = M_DOT; o_cmd.mpair = P_D; o_cmd.comp = 1'b1;
                        o_cmd.act = A_ACC;
                    end
                    4'd8: begin
                        o_cmd.mul_op = M_SGN; o_cmd.mpair = SP_AB;
                        o_cmd.act = A_DOT; o_cmd.apair = P_D;
                    end
                    4'd9: begin
                        o_cmd.mul_op = M_SGN; o_cmd.mpair = SP_DC;
                        o_cmd.act = A_SGN; o_cmd.apair = SP_AB;
                    end
                    4'd10: begin
                        o_cmd.mul_op = M_SQ;
                        o_cmd.act = A_SGN; o_cmd.apair = SP_DC;
                    end
                    4'd11: begin
                        o_cmd.mul_op = M_SQ; o_cmd.comp = 1'b1;
                        o_cmd.act = A_SQ0;
                    end
                    4'd12: begin
                        o_cmd.act = A_DECIDE;
                        n_state = i_status.stop ? ST_OUT : ST_MID;
                    end
                    default: n_state = ST_MID;
                endcase
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.act = A_PUSH;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    // an accepted beat locks the input side out on the next cycle
    a_accept_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not locked after accept");

    // horner stage never passes the last stage
    a_stage_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stage != 2'd3)
        else $error("horner stage out of range");

    // a pass sequence never runs past its decision step
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PDOT) |-> (r_step <= 4'd12))
        else $error("pass step out of range");

    // the result push only happens with room at the output
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.act == A_PUSH) |-> i_status.out_free)
        else $error("push without room");
`endif

endmodule

// ===== rtl/core/ccpp_dp.sv =====
// datapath for the cubic curve point projection core
// configuration registers, shared multiplier, horner, dot and decision logic; uses ccpp_pkg
`timescale 1ns / 1ps

module ccpp_dp import ccpp_pkg::*; #(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int MAX_PASSES = MAX_PASSES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic signed [31:0] o_proj_x,
    output logic signed [31:0] o_proj_y,
    output logic [6:0]         o_pass_count
);

    localparam int DW = 65 - FRAC_BITS;
    localparam int PW = $clog2(MAX_PASSES);
    localparam int UP = 24 - FRAC_BITS;
    localparam logic [63:0] DEADBAND =
        ((64'd1 << (2 * FRAC_BITS)) + 64'd999999) / 64'd1000000;
    localparam logic [63:0] LIM47  = 64'd1 << 47;
    localparam logic [63:0] PH_LIM = LIM47 >> UP;
    localparam longint LOW_L  = -10 * (longint'(1) << FRAC_BITS);
    localparam longint HIGH_L = 100 * (longint'(1) << FRAC_BITS);
    localparam logic signed [31:0] LOW_RST =
        (LOW_L < -64'sd2147483648) ? 32'sh8000_0000 : 32'(LOW_L);
    localparam logic signed [31:0] HIGH_RST =
        (HIGH_L > 64'sd2147483647) ? 32'sh7fff_ffff : 32'(HIGH_L);
    localparam logic [30:0] TOL_RST = 31'((64'd1 << FRAC_BITS) / 64'd100);
    localparam logic signed [50:0] S47P = 51'sd140737488355328;
    localparam logic signed [50:0] S47N = -51'sd140737488355328;

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
        mag = v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    // configuration
    logic signed [31:0] r_coef_const, r_coef_linear, r_coef_square, r_coef_cube;
    logic [30:0]        r_tolerance;
    logic signed [31:0] r_search_low, r_search_high;

    // working registers
    logic signed [31:0] r_px, r_py, r_xs, r_ys, r_xe, r_ye, r_xm, r_ym, r_cx, r_y;
    logic signed [48:0] r_h;
    logic [63:0]        r_ph, r_prod;
    logic               r_pneg;
    logic [61:0]        r_tol2;
    logic [62:0]        r_sq;
    logic signed [DW-1:0] r_acc, r_da, r_db, r_dc, r_dd;
    logic signed [31:0] r_vps [2];
    logic signed [31:0] r_vpe [2];
    logic signed [31:0] r_vpm [2];
    logic signed [31:0] r_vms [2];
    logic signed [31:0] r_vem [2];
    logic               r_big_ab, r_big_dc, r_big_ac, r_have;
    logic signed [31:0] r_rx, r_ry;
    logic [PW-1:0]      r_pass;
    logic [6:0]         r_cnt;
    logic               r_out_valid;
    logic signed [31:0] r_out_x, r_out_y;
    logic [6:0]         r_out_cnt;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_const  <= '0;
            r_coef_linear <= '0;
            r_coef_square <= '0;
            r_coef_cube   <= '0;
            r_tolerance   <= TOL_RST;
            r_search_low  <= LOW_RST;
            r_search_high <= HIGH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COEF_CONST:  r_coef_const  <= i_cfg_data;
                CFG_COEF_LINEAR: r_coef_linear <= i_cfg_data;
                CFG_COEF_SQUARE: r_coef_square <= i_cfg_data;
                CFG_COEF_CUBE:   r_coef_cube   <= i_cfg_data;
                CFG_TOLERANCE:   r_tolerance   <= i_cfg_data[30:0];
                CFG_SEARCH_LOW:  r_search_low  <= i_cfg_data;
                CFG_SEARCH_HIGH: r_search_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sign product operand select
    function automatic void sgn_pair(input logic [1:0] p,
                                     output logic signed [DW-1:0] s1,
                                     output logic signed [DW-1:0] s2);
        unique case (p)
            SP_AB:   begin s1 = r_da; s2 = r_db; end
            SP_DC:   begin s1 = r_dd; s2 = r_dc; end
            default: begin s1 = r_da; s2 = r_dc; end
        endcase
    endfunction

    // multiplier operand select
    logic [31:0] mul_a, mul_b;
    logic        mul_neg;
    logic [47:0] habs;
    logic [31:0] cxabs;
    logic signed [31:0] du, dv;
    logic signed [DW-1:0] ms1, ms2;
    logic [DW-1:0] mm1, mm2, mmn, mmx;

    always_comb begin
        habs  = r_h[48] ? 48'(-r_h) : 48'(r_h);
        cxabs = abs32(r_cx);
        du    = '0;
        dv    = '0;
        unique case (i_cmd.mpair)
            P_A:     begin du = r_vps[i_cmd.comp]; dv = r_vms[i_cmd.comp]; end
            P_B:     begin du = r_vpm[i_cmd.comp]; dv = r_vms[i_cmd.comp]; end
            P_C:     begin du = r_vpe[i_cmd.comp]; dv = r_vem[i_cmd.comp]; end
            default: begin du = r_vpm[i_cmd.comp]; dv = r_vem[i_cmd.comp]; end
        endcase
        sgn_pair(i_cmd.mpair, ms1, ms2);
        mm1 = mag(ms1);
        mm2 = mag(ms2);
        mmn = (mm1 < mm2) ? mm1 : mm2;
        mmx = (mm1 < mm2) ? mm2 : mm1;
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        unique case (i_cmd.mul_op)
            M_TOL: begin mul_a = {1'b0, r_tolerance}; mul_b = {1'b0, r_tolerance}; end
            M_HI:  begin mul_a = {8'b0, habs[47:24]}; mul_b = cxabs; end
            M_LO:  begin mul_a = {8'b0, habs[23:0]};  mul_b = cxabs; end
            M_DOT: begin
                mul_a   = abs32(du);
                mul_b   = abs32(dv);
                mul_neg = du[31] ^ dv[31];
            end
            M_SGN: begin mul_a = mmn[31:0]; mul_b = mmx[31:0]; end
            M_SQ: begin
                mul_a = abs32(r_vms[i_cmd.comp]);
                mul_b = abs32(r_vms[i_cmd.comp]);
            end
            default: ;
        endcase
    end

    // shared multiplier, product registered
    always_ff @(posedge i_clk) begin
        r_prod <= {32'b0, mul_a} * {32'b0, mul_b};
        r_pneg <= mul_neg;
    end

    // horner stage combine: floor(h*x / 2^s) saturated, plus coefficient
    logic        neg_h, hcorr, hsat;
    logic [65:0] ph_sh, pl_sh, hq;
    logic [47:0] hq_c;
    logic signed [49:0] hms;
    logic signed [31:0] hcoef;
    logic signed [50:0] hsum;
    logic signed [48:0] h_next;
    logic signed [31:0] y_next;

    always_comb begin
        neg_h = r_h[48] ^ r_cx[31];
        if (i_cmd.stage == HORNER_LAST) begin
            ph_sh = {2'b0, r_ph};
            pl_sh = 66'(r_prod >> 24);
            hcorr = neg_h && (r_prod[23:0] != '0);
            hsat  = r_ph > LIM47;
        end else begin
            ph_sh = {2'b0, r_ph} << UP;
            pl_sh = 66'(r_prod >> FRAC_BITS);
            hcorr = neg_h && (r_prod[FRAC_BITS-1:0] != '0);
            hsat  = r_ph > PH_LIM;
        end
        hq   = ph_sh + pl_sh + 66'(hcorr);
        hq_c = (hsat || hq > 66'(LIM47)) ? LIM47[47:0] : hq[47:0];
        hms  = neg_h ? -$signed({2'b0, hq_c}) : $signed({2'b0, hq_c});
        unique case (i_cmd.stage)
            2'd0:    hcoef = r_coef_square;
            2'd1:    hcoef = r_coef_linear;
            default: hcoef = r_coef_const;
        endcase
        hsum = 51'(hms) + 51'(hcoef);
        if (hsum > S47P)
            h_next = 49'(S47P);
        else if (hsum < S47N)
            h_next = 49'(S47N);
        else
            h_next = hsum[48:0];
        if (hsum > 51'sd2147483647)
            y_next = 32'sh7fff_ffff;
        else if (hsum < -51'sd2147483648)
            y_next = 32'sh8000_0000;
        else
            y_next = hsum[31:0];
    end

    // floored dot product term
    logic signed [64:0] pterm;
    logic signed [DW-1:0] term;

    always_comb begin
        pterm = r_pneg ? -$signed({1'b0, r_prod}) : $signed({1'b0, r_prod});
        term  = DW'(pterm >>> FRAC_BITS);
    end

    // dead band test on the pair named by the act
    logic signed [DW-1:0] as1, as2;
    logic [DW-1:0] am1, am2, amx;
    logic big;

    always_comb begin
        sgn_pair(i_cmd.apair, as1, as2);
        am1 = mag(as1);
        am2 = mag(as2);
        amx = (am1 < am2) ? am2 : am1;
        big = (as1 != '0) && (as2 != '0) &&
              ((64'(amx) >= DEADBAND) || (r_prod >= DEADBAND));
    end

    // pass decision
    logic go_low, go_high, a_zero, c_zero, undec, close, brk, last, stop, have_n;
    logic signed [31:0] rx_n, ry_n, fx, fy;
    logic [PW:0] cnt_w;
    logic [6:0]  cnt_n;
    logic signed [32:0] msum;

    always_comb begin
        go_low  = r_big_ab && (r_da[DW-1] ^ r_db[DW-1]) &&
                  r_big_dc && !(r_dd[DW-1] ^ r_dc[DW-1]);
        go_high = r_big_ab && !(r_da[DW-1] ^ r_db[DW-1]) &&
                  r_big_dc && (r_dd[DW-1] ^ r_dc[DW-1]);
        a_zero  = (r_da == '0);
        c_zero  = (r_dc == '0);
        undec   = !go_low && !go_high && !a_zero && !c_zero;
        close   = (64'(r_sq) + 64'(r_prod[62:0])) < 64'(r_tol2);
        brk     = undec || close;
        last    = (r_pass == PW'(MAX_PASSES - 1));
        stop    = brk || last;
        have_n  = r_have || (!go_low && !go_high && (a_zero || c_zero));
        rx_n    = r_rx;
        ry_n    = r_ry;
        if (!go_low && !go_high) begin
            if (a_zero) begin
                rx_n = r_xs; ry_n = r_ys;
            end else if (c_zero) begin
                rx_n = r_xe; ry_n = r_ye;
            end
        end
        if (brk || !have_n) begin
            fx = r_xm; fy = r_ym;
        end else begin
            fx = rx_n; fy = ry_n;
        end
        cnt_w = {1'b0, r_pass} + (PW + 1)'(!brk);
        cnt_n = (cnt_w > (PW + 1)'(127)) ? 7'd127 : 7'(cnt_w);
        msum  = 33'(r_xs) + 33'(r_xe);
    end

    assign o_status.bracket  = r_big_ac && (r_da[DW-1] ^ r_dc[DW-1]);
    assign o_status.stop     = stop;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    // working register updates
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.act)
            A_LOAD: begin
                r_px <= i_point_x;
                r_py <= i_point_y;
                r_xs <= r_search_low;
                r_xe <= r_search_high;
                r_have <= 1'b0;
            end
            A_TOL_XS: begin
                r_tol2 <= r_prod[61:0];
                r_cx   <= r_xs;
                r_h    <= 49'(r_coef_cube);
            end
            A_SAVE_PH: r_ph <= r_prod;
            A_HORNER: begin
                r_h <= h_next;
                r_y <= y_next;
            end
            A_YS_XE: begin
                r_ys <= r_y;
                r_cx <= r_xe;
                r_h  <= 49'(r_coef_cube);
            end
            A_VEC_INIT: begin
                r_ye     <= r_y;
                r_vps[0] <= diff32(r_xs, r_px);
                r_vps[1] <= diff32(r_ys, r_py);
                r_vpe[0] <= diff32(r_xe, r_px);
                r_vpe[1] <= diff32(r_y, r_py);
                r_vms[0] <= diff32(r_xe, r_xs);
                r_vms[1] <= diff32(r_y, r_ys);
                r_vem[0] <= diff32(r_xe, r_xs);
                r_vem[1] <= diff32(r_y, r_ys);
            end
            A_ACC: r_acc <= term;
            A_DOT: begin
                unique case (i_cmd.apair)
                    P_A:     r_da <= r_acc + term;
                    P_B:     r_db <= r_acc + term;
                    P_C:     r_dc <= r_acc + term;
                    default: r_dd <= r_acc + term;
                endcase
            end
            A_SGN: begin
                unique case (i_cmd.apair)
                    SP_AB:   r_big_ab <= big;
                    SP_DC:   r_big_dc <= big;
                    default: r_big_ac <= big;
                endcase
            end
            A_SQ0: r_sq <= r_prod[62:0];
            A_PX: begin
                r_cx <= r_px;
                r_h  <= 49'(r_coef_cube);
            end
            A_RES_Y: begin
                r_rx  <= r_px;
                r_ry  <= r_y;
                r_cnt <= '0;
            end
            A_MID: begin
                r_xm <= msum[32:1];
                r_cx <= msum[32:1];
                r_h  <= 49'(r_coef_cube);
            end
            A_VEC_PASS: begin
                r_ym     <= r_y;
                r_vpm[0] <= diff32(r_xm, r_px);
                r_vpm[1] <= diff32(r_y, r_py);
                r_vms[0] <= diff32(r_xs, r_xm);
                r_vms[1] <= diff32(r_ys, r_y);
                r_vem[0] <= diff32(r_xm, r_xe);
                r_vem[1] <= diff32(r_y, r_ye);
            end
            A_DECIDE: begin
                r_have <= have_n;
                r_cnt  <= cnt_n;
                if (stop) begin
                    r_rx <= fx;
                    r_ry <= fy;
                end else begin
                    r_rx <= rx_n;
                    r_ry <= ry_n;
                end
                if (go_low) begin
                    r_xe     <= r_xm;
                    r_ye     <= r_ym;
                    r_vpe[0] <= r_vpm[0];
                    r_vpe[1] <= r_vpm[1];
                end else if (go_high) begin
                    r_xs     <= r_xm;
                    r_ys     <= r_ym;
                    r_vps[0] <= r_vpm[0];
                    r_vps[1] <= r_vpm[1];
                end
            end
            default: ;
        endcase
    end

    // pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_pass <= '0;
        else if (i_cmd.act == A_LOAD)
            r_pass <= '0;
        else if (i_cmd.act == A_MID)
            r_pass <= r_pass + PW'(1);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (i_cmd.act == A_PUSH)
            r_out_valid <= 1'b1;
        else if (!i_out_stall)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.act == A_PUSH) begin
            r_out_x   <= r_rx;
            r_out_y   <= r_ry;
            r_out_cnt <= r_cnt;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_proj_x     = r_out_x;
    assign o_proj_y     = r_out_y;
    assign o_pass_count = r_out_cnt;

endmodule

// ===== rtl/core/cubic_curve_point_projection_core.sv =====
// Projects a point onto the cubic y = c0 + c1*x + c2*x^2 + c3*x^3 by bisection.
// Input channel: i_in_valid / o_in_stall carry one beat (i_point_x, i_point_y),
// accepted when valid is high and stall is low.
// Output channel: o_out_valid / i_out_stall carry one beat (o_proj_x, o_proj_y,
// o_pass_count) per input beat, held stable while i_out_stall is high.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 const, 1 linear, 2 square, 3 cube, 4 tolerance, 5 search low, 6 search high).
// One item is in work at a time; o_in_stall stays high from accept until the
// result has moved into the output register.
// Each item first evaluates the cubic at both bounds, forms the dot products and
// tests the bracket; a bracketed point then runs bisection passes, each one cubic
// evaluation followed by dot products, dead band tests and distance check, while
// an unbracketed point takes one further cubic evaluation at the point's x.
// All products go through one shared 32x32 multiplier.
// A result that waits on a stalled receiver holds the item in its final state,
// with the input stalled, until the output register frees.
// Reset (synchronous, active low) loads the default coefficients and bounds
// and empties the output register.
`timescale 1ns / 1ps

module cubic_curve_point_projection_core import ccpp_pkg::*; #(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int MAX_PASSES = MAX_PASSES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_proj_x,
    output logic signed [31:0] o_proj_y,
    output logic [6:0]         o_pass_count
);

    t_cmd    cmd;
    t_status status;

    // sequencer
    ccpp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath
    ccpp_dp #(
        .FRAC_BITS  (FRAC_BITS),
        .MAX_PASSES (MAX_PASSES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_proj_x     (o_proj_x),
        .o_proj_y     (o_proj_y),
        .o_pass_count (o_pass_count)
    );

endmodule
